FILE: rtl/core/sas_pkg.sv
// Shared types, constants and helpers of the sprite animation script sequencer.
package sas_pkg;

  // Default sizes of the script store and of the skip bound
  localparam int unsigned SCRIPT_ENTRIES_DEF = 512;
  localparam int unsigned SKIP_LIMIT_DEF     = 513;

  // Field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned IDX_W   = 9;
  localparam int unsigned DUR_W   = 16;
  localparam int unsigned FRM_W   = 16;
  localparam int unsigned RATE_W  = 16;
  localparam int unsigned WORD_W  = DUR_W + FRM_W;
  localparam int unsigned PROD_W  = DUR_W + RATE_W;
  localparam int unsigned SUM_W   = PROD_W + 1;
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned CNT_W   = SUM_W - FRAC_W;
  localparam int unsigned CFG_W   = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  // Configuration register indexes
  localparam logic CFG_RATE  = 1'b0;
  localparam logic CFG_START = 1'b1;

  // Command codes carried in the frame field of a zero-duration entry
  localparam logic [FRM_W-1:0] CMD_LOOP   = 16'hFFFF;
  localparam logic [FRM_W-1:0] CMD_STOP   = 16'h0000;
  localparam logic [FRM_W-1:0] CMD_DELETE = 16'h0001;

  // Rate constants: reset value and the unit rate used by a restart
  localparam logic [RATE_W-1:0] RATE_RESET = 16'h0100;
  localparam logic [RATE_W-1:0] RATE_UNIT  = 16'h0100;

  // Result of one transaction
  typedef struct packed {
    logic             running;
    logic             active;
    logic             new_frame;
    logic [FRM_W-1:0] frame_id;
    logic             stuck;
  } res_t;

  // Reduce a start index modulo the store depth (depth is at least 16,
  // so five conditional subtractions cover every 9-bit value)
  function automatic logic [IDX_W-1:0] start_mod(input logic [IDX_W-1:0] v,
                                                 input int unsigned depth);
    logic [IDX_W-1:0] r;
    r = v;
    for (int k = 4; k >= 0; k--) begin
      if (32'(r) >= (depth << k)) begin
        r = IDX_W'(32'(r) - (depth << k));
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/sas_script_mem.sv
// Script store: single-port-write, registered-read memory of script entries.
module sas_script_mem #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9,
  parameter int unsigned DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/sas_engine.sv
// Script engine: transaction decode, countdown and the serial walk over script entries.
module sas_engine #(
  parameter int unsigned SCRIPT_ENTRIES = 512,
  parameter int unsigned SKIP_LIMIT     = 513,
  parameter int unsigned AW             = 9
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Input transaction
  input  logic                    in_start,
  output logic                    in_idle,
  input  logic [sas_pkg::OP_W-1:0]  in_operation,
  input  logic [sas_pkg::IDX_W-1:0] in_entry_index,
  input  logic [sas_pkg::DUR_W-1:0] in_entry_duration,
  input  logic [sas_pkg::FRM_W-1:0] in_entry_frame,
  // Configuration
  input  logic [sas_pkg::RATE_W-1:0] cfg_rate,
  input  logic [AW-1:0]             cfg_start_idx,
  // Script store
  output logic                      mem_we,
  output logic [AW-1:0]             mem_waddr,
  output logic [sas_pkg::WORD_W-1:0] mem_wdata,
  output logic                      mem_re,
  output logic [AW-1:0]             mem_raddr,
  input  logic [sas_pkg::WORD_W-1:0] mem_rdata,
  // Result
  output logic                      res_valid,
  input  logic                      res_ack,
  output sas_pkg::res_t             res
);
  import sas_pkg::*;

  localparam int unsigned SW = $clog2(SKIP_LIMIT + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_EVAL,
    S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       ptr_r, ptr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [FRAC_W-1:0]   frac_r, frac_nxt;
  logic                active_r, active_nxt;
  logic [FRM_W-1:0]    shown_r, shown_nxt;
  logic [RATE_W-1:0]   rate_r, rate_nxt;
  logic [SW-1:0]       skip_r, skip_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic                running_r, running_nxt;
  logic                new_frame_r, new_frame_nxt;
  logic                stuck_r, stuck_nxt;

  logic [DUR_W-1:0]    rd_dur;
  logic [FRM_W-1:0]    rd_frm;
  logic [SUM_W-1:0]    sum;
  logic [AW-1:0]       ptr_next_idx;
  logic [SW-1:0]       skip_inc;

  assign rd_dur       = mem_rdata[WORD_W-1:FRM_W];
  assign rd_frm       = mem_rdata[FRM_W-1:0];
  assign sum          = SUM_W'(frac_r) + SUM_W'(prod_r);
  assign ptr_next_idx = (ptr_r == AW'(SCRIPT_ENTRIES - 1)) ? '0 : ptr_r + 1'b1;
  assign skip_inc     = skip_r + 1'b1;

  assign in_idle   = (state_r == S_IDLE);
  assign res_valid = (state_r == S_OUT);

  assign mem_waddr = AW'(in_entry_index);
  assign mem_wdata = {in_entry_duration, in_entry_frame};
  assign mem_raddr = ptr_r;

  assign res.running   = running_r;
  assign res.active    = active_r;
  assign res.new_frame = new_frame_r;
  assign res.frame_id  = shown_r;
  assign res.stuck     = stuck_r;

  // Next-state and datapath decisions
  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    frac_nxt      = frac_r;
    active_nxt    = active_r;
    shown_nxt     = shown_r;
    rate_nxt      = rate_r;
    skip_nxt      = skip_r;
    prod_nxt      = prod_r;
    running_nxt   = running_r;
    new_frame_nxt = new_frame_r;
    stuck_nxt     = stuck_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_start) begin
          running_nxt   = 1'b0;
          new_frame_nxt = 1'b0;
          stuck_nxt     = 1'b0;
          skip_nxt      = '0;
          state_nxt     = S_OUT;
          case (in_operation)
            OP_TICK: begin
              rate_nxt = cfg_rate;
              if (!active_r) begin
                state_nxt = S_OUT;
              end else if (cfg_rate == '0) begin
                running_nxt = 1'b1;
              end else if (cnt_r != '0) begin
                cnt_nxt = cnt_r - 1'b1;
                if (cnt_r != CNT_W'(1)) begin
                  running_nxt = 1'b1;
                end else begin
                  ptr_nxt   = ptr_next_idx;
                  state_nxt = S_READ;
                end
              end else begin
                state_nxt = S_READ;
              end
            end
            OP_WRITE: begin
              mem_we = (32'(in_entry_index) < SCRIPT_ENTRIES);
            end
            OP_RESTART: begin
              if (!active_r) begin
                frac_nxt = '0;
              end
              active_nxt = 1'b1;
              ptr_nxt    = cfg_start_idx;
              cnt_nxt    = '0;
              rate_nxt   = RATE_UNIT;
              state_nxt  = S_READ;
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end

      // Fetch the entry under the pointer
      S_READ: begin
        mem_re    = 1'b1;
        state_nxt = S_MUL;
      end

      // Scale the duration by the rate
      S_MUL: begin
        prod_nxt  = PROD_W'(rd_dur) * PROD_W'(rate_r);
        state_nxt = S_EVAL;
      end

      // Decide: command, shown frame, or skip on to the next entry or loop start until the skip bound
      S_EVAL: begin
        if (rd_dur == '0 && rd_frm == CMD_STOP) begin
          state_nxt = S_OUT;
        end else if (rd_dur == '0 && rd_frm == CMD_DELETE) begin
          active_nxt = 1'b0;
          state_nxt  = S_OUT;
        end else if (rd_dur != '0 && sum[SUM_W-1:FRAC_W] != '0) begin
          cnt_nxt       = sum[SUM_W-1:FRAC_W];
          frac_nxt      = sum[FRAC_W-1:0];
          shown_nxt     = rd_frm;
          new_frame_nxt = 1'b1;
          running_nxt   = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          if (rd_dur == '0 && rd_frm == CMD_LOOP) begin
            ptr_nxt = cfg_start_idx;
          end else begin
            frac_nxt = sum[FRAC_W-1:0];
            ptr_nxt  = ptr_next_idx;
          end
          skip_nxt = skip_inc;
          if (skip_inc == SW'(SKIP_LIMIT)) begin
            cnt_nxt     = '0;
            stuck_nxt   = 1'b1;
            running_nxt = 1'b1;
            state_nxt   = S_OUT;
          end else begin
            state_nxt = S_READ;
          end
        end
      end

      // Hold the result until the output register takes it
      S_OUT: begin
        if (res_ack) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      cnt_r       <= '0;
      frac_r      <= '0;
      active_r    <= 1'b0;
      shown_r     <= '0;
      running_r   <= 1'b0;
      new_frame_r <= 1'b0;
      stuck_r     <= 1'b0;
      skip_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
      frac_r      <= frac_nxt;
      active_r    <= active_nxt;
      shown_r     <= shown_nxt;
      running_r   <= running_nxt;
      new_frame_r <= new_frame_nxt;
      stuck_r     <= stuck_nxt;
      skip_r      <= skip_nxt;
    end
    rate_r <= rate_nxt;
    prod_r <= prod_nxt;
  end

endmodule

FILE: rtl/core/sprite_animation_script_sequencer_top.sv
// Top level of the sprite animation script sequencer: config registers, engine, store, output register.
//
//  port group | direction | handshake            | payload
//  -----------+-----------+----------------------+-----------------------------------------------
//  in_*       | input     | in_valid / in_ready  | operation, entry_index, entry_duration, entry_frame
//  out_*      | output    | out_valid / out_ready| running, active, new_frame, frame_id, stuck
//  cfg_*      | input     | cfg_valid / cfg_ready| cfg_index (0 rate_q8, 1 script_start), cfg_data
//
// One transaction at a time. A write, an unused code, or a tick that only counts
// down goes from idle straight to the result; each script entry examined passes through
// a store read, a multiply and an evaluate, and a tick or restart examines up to SKIP_LIMIT entries.
// Synchronous active-low reset clears control state; the script store is not cleared.
// A finished result waits in the output register while the next transaction is taken;
// a stalled output holds the engine only once the next result is ready.
module sprite_animation_script_sequencer_top #(
  parameter int unsigned SCRIPT_ENTRIES = sas_pkg::SCRIPT_ENTRIES_DEF,
  parameter int unsigned SKIP_LIMIT     = sas_pkg::SKIP_LIMIT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [sas_pkg::OP_W-1:0]   in_operation,
  input  logic [sas_pkg::IDX_W-1:0]  in_entry_index,
  input  logic [sas_pkg::DUR_W-1:0]  in_entry_duration,
  input  logic [sas_pkg::FRM_W-1:0]  in_entry_frame,
  // Result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_running,
  output logic                       out_active,
  output logic                       out_new_frame,
  output logic [sas_pkg::FRM_W-1:0]  out_frame_id,
  output logic                       out_stuck,
  // Configuration channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [sas_pkg::CFG_W-1:0]  cfg_data
);
  import sas_pkg::*;

  localparam int unsigned AW = $clog2(SCRIPT_ENTRIES);

  logic [RATE_W-1:0] rate_r;
  logic [AW-1:0]     start_r;
  logic              in_start;
  logic              in_idle;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;
  logic              res_valid;
  logic              res_ack;
  res_t              res;
  logic              out_valid_r;
  res_t              out_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = in_idle;
  assign in_start  = in_valid && in_ready;

  // Configuration registers; the start index is reduced into the store on write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= RATE_RESET;
      start_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RATE:  rate_r  <= cfg_data;
        CFG_START: start_r <= AW'(start_mod(cfg_data[IDX_W-1:0], SCRIPT_ENTRIES));
        default:   rate_r  <= rate_r;
      endcase
    end
  end

  sas_engine #(
    .SCRIPT_ENTRIES (SCRIPT_ENTRIES),
    .SKIP_LIMIT     (SKIP_LIMIT),
    .AW             (AW)
  ) u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_start          (in_start),
    .in_idle           (in_idle),
    .in_operation      (in_operation),
    .in_entry_index    (in_entry_index),
    .in_entry_duration (in_entry_duration),
    .in_entry_frame    (in_entry_frame),
    .cfg_rate          (rate_r),
    .cfg_start_idx     (start_r),
    .mem_we            (mem_we),
    .mem_waddr         (mem_waddr),
    .mem_wdata         (mem_wdata),
    .mem_re            (mem_re),
    .mem_raddr         (mem_raddr),
    .mem_rdata         (mem_rdata),
    .res_valid         (res_valid),
    .res_ack           (res_ack),
    .res               (res)
  );

  sas_script_mem #(
    .DEPTH (SCRIPT_ENTRIES),
    .AW    (AW),
    .DW    (WORD_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: load when empty or being drained
  assign res_ack = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ack) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid && res_ack) begin
      out_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_running   = out_r.running;
  assign out_active    = out_r.active;
  assign out_new_frame = out_r.new_frame;
  assign out_frame_id  = out_r.frame_id;
  assign out_stuck     = out_r.stuck;

  // One transaction in flight: the engine leaves idle right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction was in flight");

  // A shown frame or a skip-bound hit always comes from a running, active slot
  a_frame_implies_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_new_frame || out_stuck) |-> out_running && out_active)
    else $error("new frame or stuck reported without running active slot");

  // A result never both shows a frame and reports the skip bound
  a_frame_or_stuck: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_new_frame && out_stuck))
    else $error("new frame and stuck reported together");

  // An inactive slot never reports running
  a_inactive_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_active |-> !out_running)
    else $error("running reported for an inactive slot");

endmodule

FILE: verif/tb_top.sv
// Testbench for the sprite animation script sequencer: directed and random script playback.
`timescale 1ns / 1ps

module tb_top;
  import sas_pkg::*;

  localparam int unsigned SCRIPT_DEPTH = SCRIPT_ENTRIES_DEF;
  localparam int unsigned SKIP_BOUND   = SKIP_LIMIT_DEF;
  // Longest single transaction, walking up to the skip bound of entries, plus a margin
  localparam int unsigned DRAIN_CYCLES = 2 + 3 * SKIP_BOUND + 16;
  // Code the block does not decode; it must be ignored
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [OP_W-1:0]     in_operation;
  logic [IDX_W-1:0]    in_entry_index;
  logic [DUR_W-1:0]    in_entry_duration;
  logic [FRM_W-1:0]    in_entry_frame;
  logic                out_valid;
  logic                out_ready;
  logic                out_running;
  logic                out_active;
  logic                out_new_frame;
  logic [FRM_W-1:0]    out_frame_id;
  logic                out_stuck;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_index;
  logic [CFG_W-1:0]    cfg_data;

  // Shadow copy of the animation state
  logic [WORD_W-1:0]   script_words [SCRIPT_DEPTH];
  logic [IDX_W-1:0]    play_pos;
  logic [CNT_W-1:0]    frame_ticks;
  logic [FRAC_W-1:0]   frac_q8;
  logic                slot_busy;
  logic [FRM_W-1:0]    frame_shown;
  logic [RATE_W-1:0]   playback_rate;
  logic [IDX_W-1:0]    loop_start;

  res_t                status_q [$];
  int                  mismatch_count;
  int                  items_sent;
  bit                  steady_flow;

  sprite_animation_script_sequencer_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_entry_index    (in_entry_index),
    .in_entry_duration (in_entry_duration),
    .in_entry_frame    (in_entry_frame),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_running       (out_running),
    .out_active        (out_active),
    .out_new_frame     (out_new_frame),
    .out_frame_id      (out_frame_id),
    .out_stuck         (out_stuck),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Advance the animation by one step at the given rate
  function automatic void play_step(input logic [RATE_W-1:0] rate, output logic run,
                                    output logic shown_new, output logic hit_bound);
    logic [WORD_W-1:0] word;
    logic [DUR_W-1:0]  dur;
    logic [FRM_W-1:0]  frm;
    logic [SUM_W-1:0]  sum;
    run = 1'b0;
    shown_new = 1'b0;
    hit_bound = 1'b0;
    if (!slot_busy) return;
    if (rate == '0) begin
      run = 1'b1;
      return;
    end
    // Count down the frame on screen; move on once it expires
    if (frame_ticks != '0) begin
      frame_ticks = frame_ticks - 1'b1;
      if (frame_ticks != '0) begin
        run = 1'b1;
        return;
      end
      play_pos = play_pos + 1'b1;
    end
    // Walk entries until one lasts at least a whole tick
    for (int n = 0; n < SKIP_BOUND; n++) begin
      word = script_words[play_pos];
      dur = word[WORD_W-1:FRM_W];
      frm = word[FRM_W-1:0];
      if (dur == '0) begin
        if (frm == CMD_LOOP) begin
          play_pos = loop_start;
          continue;
        end
        if (frm == CMD_STOP) return;
        if (frm == CMD_DELETE) begin
          slot_busy = 1'b0;
          return;
        end
      end
      sum = SUM_W'(frac_q8) + SUM_W'(dur) * SUM_W'(rate);
      if (sum >= SUM_W'(RATE_UNIT)) begin
        frame_ticks = sum[SUM_W-1:FRAC_W];
        frac_q8 = sum[FRAC_W-1:0];
        frame_shown = frm;
        shown_new = 1'b1;
        run = 1'b1;
        return;
      end
      frac_q8 = sum[FRAC_W-1:0];
      play_pos = play_pos + 1'b1;
    end
    frame_ticks = '0;
    hit_bound = 1'b1;
    run = 1'b1;
  endfunction

  // Apply one transaction to the shadow state and return the status it reports
  function automatic res_t sequence_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                         input logic [DUR_W-1:0] dur,
                                         input logic [FRM_W-1:0] frm);
    res_t r;
    logic run;
    logic shown_new;
    logic hit_bound;
    run = 1'b0;
    shown_new = 1'b0;
    hit_bound = 1'b0;
    case (op)
      OP_TICK: play_step(playback_rate, run, shown_new, hit_bound);
      OP_WRITE: script_words[idx] = {dur, frm};
      OP_RESTART: begin
        if (!slot_busy) frac_q8 = '0;
        slot_busy = 1'b1;
        play_pos = loop_start;
        frame_ticks = '0;
        play_step(RATE_UNIT, run, shown_new, hit_bound);
      end
      default: ;
    endcase
    r.running = run;
    r.active = slot_busy;
    r.new_frame = shown_new;
    r.frame_id = frame_shown;
    r.stuck = hit_bound;
    return r;
  endfunction

  function automatic int pick_wait();
    if (steady_flow) return 0;
    return $urandom_range(0, 13);
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return 16'h00FF;
      4: return RATE_UNIT;
      5: return 16'($urandom);
      default: return 16'($urandom_range(16'h20, 16'h200));
    endcase
  endfunction

  // Start index with random upper bits in the register word
  function automatic logic [CFG_W-1:0] pick_start_word();
    logic [IDX_W-1:0] start;
    case ($urandom_range(0, 5))
      0: start = '0;
      1: start = IDX_W'(SCRIPT_DEPTH - 1);
      default: start = IDX_W'($urandom);
    endcase
    return {7'($urandom), start};
  endfunction

  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(0, 23))
      0: return 16'($urandom_range(1, 16'hFFFF));
      1, 2, 3: return 16'($urandom_range(16'h40, 16'hFF));
      default: return 16'($urandom_range(1, 4));
    endcase
  endfunction

  // Send one transaction and record its expected status at acceptance
  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [DUR_W-1:0] dur, input logic [FRM_W-1:0] frm);
    int gap;
    gap = pick_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_entry_index <= idx;
    in_entry_duration <= dur;
    in_entry_frame <= frm;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    status_q.push_back(sequence_item(op, idx, dur, frm));
    if (op != OP_UNUSED) items_sent++;
  endtask

  // Drop the input and wait until every status has come back
  task automatic wait_idle();
    if (in_valid) in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
  endtask

  // Write both registers back to back while the block is idle
  task automatic load_settings(input logic [RATE_W-1:0] rate, input logic [CFG_W-1:0] start_word);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_RATE;
    cfg_data <= rate;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    playback_rate = rate;
    cfg_index <= CFG_START;
    cfg_data <= start_word;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    loop_start = start_word[IDX_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  task automatic compare_field(input string field, input logic [FRM_W-1:0] want,
                               input logic [FRM_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatch_count++;
    end
  endtask

  // Check each returned status against the oldest expectation
  always @(posedge clk) begin : status_check
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (status_q.size() == 0) begin
        $error("status with no transaction pending: frame_id %0h", out_frame_id);
        mismatch_count++;
      end else begin
        want = status_q.pop_front();
        compare_field("running", FRM_W'(want.running), FRM_W'(out_running));
        compare_field("active", FRM_W'(want.active), FRM_W'(out_active));
        compare_field("new_frame", FRM_W'(want.new_frame), FRM_W'(out_new_frame));
        compare_field("frame_id", want.frame_id, out_frame_id);
        compare_field("stuck", FRM_W'(want.stuck), FRM_W'(out_stuck));
      end
    end
  end

  // Stall the result channel a random number of cycles per transaction
  initial begin : result_drain
    int stall;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = pick_wait();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  // Ticks and unused codes before any script exists
  task automatic test_idle_slot();
    send_item(OP_TICK, '0, '0, '0);
    send_item(OP_UNUSED, IDX_W'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Fill every entry so playback never reads an unwritten one
  task automatic test_script_fill();
    logic [DUR_W-1:0] dur;
    logic [FRM_W-1:0] frm;
    for (int i = 0; i < SCRIPT_DEPTH; i++) begin
      steady_flow = (i >= SCRIPT_DEPTH / 2);
      frm = 16'($urandom);
      case ($urandom_range(0, 15))
        0: begin
          dur = '0;
          frm = CMD_LOOP;
        end
        1: begin
          dur = '0;
          frm = CMD_STOP;
        end
        2: begin
          dur = '0;
          frm = CMD_DELETE;
        end
        default: dur = pick_duration();
      endcase
      send_item(OP_WRITE, IDX_W'(i), dur, frm);
    end
    steady_flow = 1'b0;
  endtask

  // Reset rate and start: plain playback through a loop
  task automatic test_unit_rate_playback();
    send_item(OP_WRITE, 9'd0, 16'd1, 16'h1234);
    send_item(OP_WRITE, 9'd1, 16'd2, 16'hABCD);
    send_item(OP_WRITE, 9'd2, '0, CMD_LOOP);
    send_item(OP_RESTART, '0, '0, '0);
    repeat (5) send_item(OP_TICK, '0, '0, '0);
  endtask

  // Stop holds the slot, delete frees it
  task automatic test_commands();
    send_item(OP_WRITE, 9'd2, '0, CMD_STOP);
    repeat (2) send_item(OP_TICK, '0, '0, '0);
    send_item(OP_WRITE, 9'd2, '0, CMD_DELETE);
    send_item(OP_RESTART, '0, '0, '0);
    repeat (3) send_item(OP_TICK, '0, '0, '0);
  endtask

  // Last entry wraps to entry 0; largest duration times largest rate; frozen rate
  task automatic test_extreme_rates();
    load_settings(RATE_UNIT, 16'hFFFF);
    send_item(OP_WRITE, 9'd511, 16'd1, 16'hFFFF);
    send_item(OP_WRITE, 9'd0, 16'hFFFF, 16'h0000);
    send_item(OP_RESTART, '0, '0, '0);
    load_settings(16'hFFFF, 16'hFFFF);
    repeat (2) send_item(OP_TICK, '0, '0, '0);
    load_settings('0, 16'hFFFF);
    send_item(OP_TICK, '0, '0, '0);
  endtask

  // Sub-tick entries are skipped; an endless command loop hits the skip bound
  task automatic test_skip_and_bound();
    load_settings(16'd1, 16'd16);
    send_item(OP_WRITE, 9'd16, 16'd1, 16'h0010);
    send_item(OP_WRITE, 9'd17, 16'h0080, 16'h0011);
    send_item(OP_WRITE, 9'd18, 16'h00F0, 16'h0012);
    send_item(OP_RESTART, '0, '0, '0);
    repeat (2) send_item(OP_TICK, '0, '0, '0);
    load_settings(RATE_UNIT, 16'd32);
    send_item(OP_WRITE, 9'd32, '0, 16'h0007);
    send_item(OP_WRITE, 9'd33, '0, CMD_LOOP);
    send_item(OP_RESTART, '0, '0, '0);
    send_item(OP_TICK, '0, '0, '0);
  endtask

  // Short scripts at the loop start, restart, then ticks mixed with noise
  task automatic test_random_scripts();
    int goal;
    int seg_len;
    int burst;
    logic [IDX_W-1:0] base;
    // Top the whole run up to about 900 transactions
    goal = 900;
    while (items_sent < goal) begin
      steady_flow = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 0) load_settings(pick_rate(), pick_start_word());
      base = loop_start;
      seg_len = $urandom_range(1, 6);
      for (int i = 0; i < seg_len; i++)
        send_item(OP_WRITE, base + IDX_W'(i), pick_duration(), 16'($urandom));
      // Close the script with a command, or run on into older entries
      case ($urandom_range(0, 7))
        0, 1, 2: send_item(OP_WRITE, base + IDX_W'(seg_len), '0, CMD_LOOP);
        3: send_item(OP_WRITE, base + IDX_W'(seg_len), '0, CMD_STOP);
        4: send_item(OP_WRITE, base + IDX_W'(seg_len), '0, CMD_DELETE);
        5: send_item(OP_WRITE, base + IDX_W'(seg_len), '0, 16'($urandom_range(2, 16'hFFFE)));
        default: ;
      endcase
      send_item(OP_RESTART, IDX_W'($urandom), 16'($urandom), 16'($urandom));
      burst = $urandom_range(4, 30);
      for (int i = 0; i < burst; i++) begin
        case ($urandom_range(0, 29))
          0, 1, 2: send_item(OP_WRITE, IDX_W'($urandom), 16'($urandom), 16'($urandom));
          3: send_item(OP_UNUSED, IDX_W'($urandom), 16'($urandom), 16'($urandom));
          4: send_item(OP_RESTART, IDX_W'($urandom), 16'($urandom), 16'($urandom));
          default: send_item(OP_TICK, IDX_W'($urandom), 16'($urandom), 16'($urandom));
        endcase
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    in_valid <= 1'b0;
    in_operation <= OP_TICK;
    in_entry_index <= '0;
    in_entry_duration <= '0;
    in_entry_frame <= '0;
    out_ready <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_RATE;
    cfg_data <= '0;
    rst_n <= 1'b0;
    play_pos = '0;
    frame_ticks = '0;
    frac_q8 = '0;
    slot_busy = 1'b0;
    frame_shown = '0;
    playback_rate = RATE_RESET;
    loop_start = '0;
    mismatch_count = 0;
    items_sent = 0;
    steady_flow = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_slot();
    test_script_fill();
    test_unit_rate_playback();
    test_commands();
    test_extreme_rates();
    test_skip_and_bound();
    test_random_scripts();

    // Let any stray status surface before the verdict
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #100_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
